/* hw/rtl/lpg_pkg.sv */
// Shared constants and types for the luma Perlin gain pixel block.
package lpg_pkg;

    localparam int LOG_BITS = 24;
    localparam int LOG_LAT  = LOG_BITS + 1;

    localparam logic [30:0] UNIT_Q30     = 31'h4000_0000;
    localparam logic [16:0] GAIN_NEUTRAL = 17'd32768;
    localparam logic [16:0] GAIN_FULL    = 17'd65536;

    localparam logic [15:0] W709_R = 16'd13926;
    localparam logic [15:0] W709_G = 16'd46884;
    localparam logic [15:0] W709_B = 16'd4725;
    localparam logic [15:0] W601_R = 16'd19595;
    localparam logic [15:0] W601_G = 16'd38470;
    localparam logic [15:0] W601_B = 16'd7471;
    localparam logic [14:0] AVG_MUL = 15'd21845;

    typedef enum logic [1:0] {
        REG_GAIN,
        REG_MODE,
        REG_CLAMP_W,
        REG_CLAMP_B
    } t_reg_idx;

    typedef enum logic [1:0] {
        LUMA_709,
        LUMA_601,
        LUMA_AVG,
        LUMA_MAX
    } t_luma_mode;

    typedef struct packed {
        logic [4:0]          msb;
        logic [LOG_BITS-1:0] frac;
    } t_log_res;

endpackage

/* hw/rtl/lpg_log2.sv */
// Pipelined log2: leading-one position and Q24 fraction by repeated squaring.
module lpg_log2
    import lpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x,
    output t_log_res    o_res
);

    logic [4:0]          r_msb [0:LOG_BITS];
    logic [30:0]         r_m   [0:LOG_BITS];
    logic [LOG_BITS-1:0] r_f   [0:LOG_BITS];
    logic [4:0]          w_msb;

    function automatic logic [4:0] msb_of(input logic [30:0] x);
        logic [4:0] p;
        p = '0;
        for (int i = 1; i < 31; i++) begin
            if (x[i]) p = 5'(i);
        end
        return p;
    endfunction

    assign w_msb = msb_of(i_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_msb[0] <= w_msb;
            r_m[0]   <= i_x << (5'd30 - w_msb);
            r_f[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= LOG_BITS; k++) begin : g_sq
        logic [61:0] w_sq;
        logic [31:0] w_s;
        assign w_sq = 62'(r_m[k-1]) * 62'(r_m[k-1]);
        assign w_s  = w_sq[61:30];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_msb[k] <= r_msb[k-1];
                r_f[k]   <= {r_f[k-1][LOG_BITS-2:0], w_s[31]};
                r_m[k]   <= w_s[31] ? w_s[31:1] : w_s[30:0];
            end
        end
    end

    assign o_res = '{msb: r_msb[LOG_BITS], frac: r_f[LOG_BITS]};

endmodule

/* hw/rtl/lpg_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module lpg_div
    import lpg_pkg::*;
#(
    parameter int AW = 47,
    parameter int DW = 36,
    parameter int QB = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quo
);

    localparam int HW = (AW - QB > DW) ? AW - QB : DW;

    logic [DW-1:0] r_rem [0:QB-1];
    logic [QB-1:0] r_lo  [0:QB-1];
    logic [DW-1:0] r_den [0:QB-1];
    logic [QB-1:0] r_q   [0:QB];
    logic          r_ovf [0:QB];
    logic [HW-1:0] w_hi;

    assign w_hi = HW'(i_num >> QB);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(w_hi);
            r_lo[0]  <= i_num[QB-1:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= w_hi >= HW'(i_den);
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_bit
        logic [DW:0] w_t;
        logic [DW:0] w_diff;
        logic        w_ge;
        assign w_t    = {r_rem[j-1], r_lo[j-1][QB-1]};
        assign w_ge   = w_t >= {1'b0, r_den[j-1]};
        assign w_diff = w_t - {1'b0, r_den[j-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j]   <= {r_q[j-1][QB-2:0], w_ge};
                r_ovf[j] <= r_ovf[j-1];
            end
        end
        if (j < QB) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
                    r_lo[j]  <= r_lo[j-1] << 1;
                    r_den[j] <= r_den[j-1];
                end
            end
        end
    end

    assign o_quo = r_ovf[QB] ? '1 : r_q[QB];

endmodule

/* hw/rtl/luma_perlin_gain_pixel_top.sv */
// Luma Perlin gain pixel top: luminance, gain curve, per-channel scale.
// Throughput: one word per cycle; the whole pipeline holds while the output
// word is stalled. Depth is set by the two 25-stage log2 units, the 24-stage
// power chain and the one-bit-per-stage quotient pipelines.
// Reset clears valid bits and sets gain to 0.5, other config registers to zero.
module luma_perlin_gain_pixel_top
    import lpg_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // red_in, green_in, blue_in, zero pad
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // red_out, green_out, blue_out, zero pad
    output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    o_m_tdata,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_idx,
    input  logic [16:0]                           i_cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int FB     = FRACTION_BITS;
    localparam int DATA_W = ((3*SB+7)/8)*8;
    localparam int LB     = FB + 16;
    localparam int LW     = SB + 19;
    localparam int CW     = (LW > LB + 2) ? LW : LB + 2;
    localparam int BW     = CW + 31;
    localparam int SHR    = (LB >= 30) ? LB - 30 : 0;
    localparam int SHL    = (LB < 30) ? 30 - LB : 0;
    localparam int AVG_SH = SB + 2;
    localparam longint unsigned AVG_RL = ((64'd1 << AVG_SH) + 64'd2) / 64'd3;
    localparam longint unsigned EPS_L  = ((64'd1 << LB) + 64'd50000) / 64'd100000;
    localparam int QB     = (SB > FB + 2) ? SB : FB + 2;
    localparam int VW     = QB + 2;
    localparam int KS     = FB - 14;
    localparam int KP     = (KS > 0) ? KS : 0;
    localparam int KN     = (KS < 0) ? -KS : 0;
    localparam int AW     = SB + 31 + KP;

    localparam int IX_S1  = 0;
    localparam int IX_S2  = 1;
    localparam int IX_S3  = 2;
    localparam int IX_S4  = 3;
    localparam int IX_LOG = IX_S4 + LOG_LAT;
    localparam int IX_SE  = IX_LOG + 1;
    localparam int IX_SN  = IX_SE + 1;
    localparam int IX_POW = IX_SN + LOG_BITS;
    localparam int IX_SC  = IX_POW + 1;
    localparam int IX_SP  = IX_SC + 1;
    localparam int IX_DIV = IX_SP + QB + 1;
    localparam int IX_SO  = IX_DIV + 1;
    localparam int NV     = IX_SO + 1;

    localparam logic [SB:0]            AVG_R  = (SB+1)'(AVG_RL);
    localparam logic signed [CW-1:0]   L_ONE  = $signed(CW'(1) << LB);
    localparam logic signed [CW-1:0]   L_HALF = $signed(CW'(1) << (LB - 1));
    localparam logic signed [CW-1:0]   L_EPS  = $signed(CW'(EPS_L));
    localparam logic signed [VW-1:0]   V_ONE  = $signed(VW'(1) << FB);
    localparam logic signed [VW-1:0]   V_HI   = $signed((VW'(1) << (SB - 1)) - VW'(1));
    localparam logic signed [VW-1:0]   V_LO   = -V_HI - VW'(1);

    function automatic logic [30:0] root_q30(input int k);
        logic [63:0] r;
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bv;
        r = 64'd1 << 29;
        for (int j = 0; j < k; j++) begin
            n   = r << 30;
            res = '0;
            bv  = 64'd1 << 62;
            for (int b = 0; b < 32; b++) begin
                if (n >= res + bv) begin
                    n   = n - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
            r = res;
        end
        return r[30:0];
    endfunction

    // config
    logic [16:0] r_gain;
    t_luma_mode  r_mode;
    logic        r_clw;
    logic        r_clb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_NEUTRAL;
            r_mode <= LUMA_709;
            r_clw  <= 1'b0;
            r_clb  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_GAIN:    r_gain <= i_cfg_data;
                REG_MODE:    r_mode <= t_luma_mode'(i_cfg_data[1:0]);
                REG_CLAMP_W: r_clw  <= i_cfg_data[0];
                REG_CLAMP_B: r_clb  <= i_cfg_data[0];
                default:     r_gain <= r_gain;
            endcase
        end
    end

    // valid chain, global stall
    logic [NV-1:0] r_vld;
    logic          w_en;

    assign w_en       = !r_vld[IX_SO] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[IX_SO];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], i_s_tvalid};
        end
    end

    // side data carried along the pipe
    logic [3*SB-1:0] r_pix   [IX_S1:IX_DIV];
    logic            r_lower [IX_S4:IX_POW];
    logic            r_bz    [IX_S4:IX_POW];
    logic            r_dneg  [IX_S4:IX_SC];
    logic [CW-1:0]   r_dm    [IX_S4:IX_SP];
    logic [33:0]     r_nt    [IX_SN:IX_POW];
    logic            r_ez    [IX_SN:IX_POW];
    logic [2:0]      r_neg   [IX_SP:IX_DIV];

    always_ff @(posedge i_clk) begin
        if (w_en) r_pix[IX_S1] <= i_s_tdata[3*SB-1:0];
    end

    for (genvar i = IX_S1 + 1; i <= IX_DIV; i++) begin : g_pix
        always_ff @(posedge i_clk) begin
            if (w_en) r_pix[i] <= r_pix[i-1];
        end
    end

    for (genvar i = IX_S4 + 1; i <= IX_POW; i++) begin : g_lb
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_lower[i] <= r_lower[i-1];
                r_bz[i]    <= r_bz[i-1];
            end
        end
    end

    for (genvar i = IX_S4 + 1; i <= IX_SC; i++) begin : g_dneg
        always_ff @(posedge i_clk) begin
            if (w_en) r_dneg[i] <= r_dneg[i-1];
        end
    end

    for (genvar i = IX_S4 + 1; i <= IX_SP; i++) begin : g_dm
        always_ff @(posedge i_clk) begin
            if (w_en) r_dm[i] <= r_dm[i-1];
        end
    end

    for (genvar i = IX_SN + 1; i <= IX_POW; i++) begin : g_nt
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_nt[i] <= r_nt[i-1];
                r_ez[i] <= r_ez[i-1];
            end
        end
    end

    for (genvar i = IX_SP + 1; i <= IX_DIV; i++) begin : g_neg
        always_ff @(posedge i_clk) begin
            if (w_en) r_neg[i] <= r_neg[i-1];
        end
    end

    // S1: weighted products, sum magnitude, maximum
    logic signed [SB-1:0]   w_ch [3];
    logic [15:0]            w_w  [3];
    logic signed [SB+1:0]   w_s;
    logic signed [SB-1:0]   w_max;
    logic signed [SB+16:0]  r_p  [3];
    logic [SB:0]            r_m;
    logic                   r_sneg1;
    logic signed [SB-1:0]   r_max1;

    for (genvar c = 0; c < 3; c++) begin : g_ch
        assign w_ch[c] = $signed(i_s_tdata[c*SB +: SB]);
    end

    always_comb begin
        case (r_mode)
            LUMA_601: begin
                w_w[0] = W601_R;
                w_w[1] = W601_G;
                w_w[2] = W601_B;
            end
            default: begin
                w_w[0] = W709_R;
                w_w[1] = W709_G;
                w_w[2] = W709_B;
            end
        endcase
        w_s   = w_ch[0] + w_ch[1] + w_ch[2];
        w_max = w_ch[0];
        if (w_ch[1] > w_max) w_max = w_ch[1];
        if (w_ch[2] > w_max) w_max = w_ch[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) r_p[c] <= w_ch[c] * $signed({1'b0, w_w[c]});
            r_m     <= w_s[SB+1] ? (SB+1)'(-w_s) : (SB+1)'(w_s);
            r_sneg1 <= w_s[SB+1];
            r_max1  <= w_max;
        end
    end

    // S2: sum, reciprocal product for the average
    logic signed [LW-1:0]  r_sum;
    logic [2*SB+1:0]       r_t;
    logic [SB+15:0]        r_u;
    logic                  r_sneg2;
    logic signed [SB-1:0]  r_max2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum   <= LW'(r_p[0]) + LW'(r_p[1]) + LW'(r_p[2]);
            r_t     <= (2*SB+2)'(r_m) * (2*SB+2)'(AVG_R);
            r_u     <= (SB+16)'(r_m) * (SB+16)'(AVG_MUL);
            r_sneg2 <= r_sneg1;
            r_max2  <= r_max1;
        end
    end

    // S3: luminance
    logic [SB+16:0]        w_mag;
    logic signed [CW-1:0]  w_lum;
    logic signed [CW-1:0]  r_lum;

    always_comb begin
        w_mag = (SB+17)'(r_u) + (SB+17)'(r_t >> AVG_SH);
        case (r_mode)
            LUMA_AVG: w_lum = r_sneg2 ? -$signed(CW'(w_mag)) : $signed(CW'(w_mag));
            LUMA_MAX: w_lum = CW'(r_max2) <<< 16;
            default:  w_lum = CW'(r_sum);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_lum <= w_lum;
    end

    // S4: curve base, divisor
    logic                  w_lower;
    logic [CW-1:0]         w_bv;
    logic [30:0]           w_base;
    logic signed [CW-1:0]  w_d0;
    logic signed [CW-1:0]  w_d;
    logic [30:0]           r_base;
    logic [30:0]           w_n;

    always_comb begin
        w_lower = r_lum < L_HALF;
        if (w_lower) begin
            w_bv = (r_lum > 0) ? CW'(r_lum <<< 1) : '0;
        end else begin
            w_bv = (r_lum < L_ONE) ? CW'((L_ONE - r_lum) <<< 1) : '0;
        end
        w_base = 31'((BW'(w_bv) << SHL) >> SHR);
        w_d0   = r_lum + L_EPS;
        w_d    = (w_d0 == 0) ? CW'(1) : w_d0;
        w_n    = (r_gain >= GAIN_FULL) ? 31'd1 : 31'(GAIN_FULL - r_gain);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lower[IX_S4] <= w_lower;
            r_bz[IX_S4]    <= w_base == '0;
            r_base         <= (w_base == '0) ? 31'd1 : w_base;
            r_dneg[IX_S4]  <= w_d < 0;
            r_dm[IX_S4]    <= (w_d < 0) ? CW'(-w_d) : CW'(w_d);
        end
    end

    // log2 of base and of (1 - gain)
    t_log_res w_lg_base;
    t_log_res w_lg_gain;

    lpg_log2 u_log_base (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_base),
        .o_res (w_lg_base)
    );

    lpg_log2 u_log_gain (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_n),
        .o_res (w_lg_gain)
    );

    // SE, SN: exponent times log of base
    logic [28:0] r_nl;
    logic [28:0] r_e;
    logic [57:0] w_prod;

    assign w_prod = 58'(r_nl) * 58'(r_e);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nl <= (29'(5'd30 - w_lg_base.msb) << LOG_BITS) - 29'(w_lg_base.frac);
            r_e  <= (29'(16) << LOG_BITS) - (29'(w_lg_gain.msb) << LOG_BITS)
                    - 29'(w_lg_gain.frac);
            r_nt[IX_SN] <= 34'(w_prod >> LOG_BITS);
            r_ez[IX_SN] <= r_e == '0;
        end
    end

    // power chain: product of 2^(-1/2^k) roots
    logic [30:0] r_acc [IX_SN+1:IX_POW];

    for (genvar k = 1; k <= LOG_BITS; k++) begin : g_pow
        localparam logic [30:0] ROOT = root_q30(k);
        logic [30:0] w_in;
        logic [61:0] w_pr;
        if (k == 1) begin : g_first
            assign w_in = UNIT_Q30;
        end else begin : g_next
            assign w_in = r_acc[IX_SN+k-1];
        end
        assign w_pr = 62'(w_in) * 62'(ROOT);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_acc[IX_SN+k] <= r_nt[IX_SN+k-1][LOG_BITS-k] ? w_pr[60:30] : w_in;
            end
        end
    end

    // SC: curve value
    logic [9:0]  w_ip;
    logic [30:0] w_pw;
    logic [31:0] w_up;
    logic [30:0] r_c;

    always_comb begin
        w_ip = r_nt[IX_POW][33:24];
        if (r_ez[IX_POW]) begin
            w_pw = UNIT_Q30;
        end else if (r_bz[IX_POW] || w_ip >= 10'd31) begin
            w_pw = '0;
        end else begin
            w_pw = r_acc[IX_POW] >> w_ip;
        end
        w_up = 32'h8000_0000 - {1'b0, w_pw};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_gain >= GAIN_FULL) begin
                r_c <= r_lower[IX_POW] ? '0 : UNIT_Q30;
            end else begin
                r_c <= r_lower[IX_POW] ? (w_pw >> 1) : w_up[31:1];
            end
        end
    end

    // SP: channel magnitude times curve, then divide
    logic [AW-1:0] r_num [3];
    logic [QB-1:0] w_quo [3];

    for (genvar c = 0; c < 3; c++) begin : g_scale
        logic signed [SB-1:0] w_x;
        logic [SB-1:0]        w_xm;
        logic [SB+30:0]       w_a;
        assign w_x  = $signed(r_pix[IX_SC][c*SB +: SB]);
        assign w_xm = w_x[SB-1] ? SB'(-w_x) : SB'(w_x);
        assign w_a  = (SB+31)'(w_xm) * (SB+31)'(r_c);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_num[c]        <= (AW'(w_a) << KP) >> KN;
                r_neg[IX_SP][c] <= w_x[SB-1] ^ r_dneg[IX_SC];
            end
        end

        lpg_div #(
            .AW (AW),
            .DW (CW),
            .QB (QB)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_num[c]),
            .i_den (r_dm[IX_SP]),
            .o_quo (w_quo[c])
        );
    end

    // SO: sign, clamps, saturation, neutral bypass
    logic [SB-1:0] r_out [3];

    for (genvar c = 0; c < 3; c++) begin : g_out
        logic signed [VW-1:0] w_v0;
        logic signed [VW-1:0] w_v;
        always_comb begin
            w_v0 = $signed({2'b00, w_quo[c]});
            w_v  = r_neg[IX_DIV][c] ? -w_v0 : w_v0;
            if (r_clw && w_v > V_ONE) w_v = V_ONE;
            if (r_clb && w_v < 0) w_v = '0;
            if (w_v > V_HI) w_v = V_HI;
            if (w_v < V_LO) w_v = V_LO;
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_out[c] <= (r_gain == GAIN_NEUTRAL) ? r_pix[IX_DIV][c*SB +: SB]
                                                     : w_v[SB-1:0];
            end
        end
    end

    assign o_m_tdata = DATA_W'({r_out[2], r_out[1], r_out[0]});

`ifndef SYNTH
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[IX_S1])
        else $error("accepted word did not enter the pipe");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |=> $stable(r_vld))
        else $error("pipe moved during a stall");

    a_curve_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[IX_SC] |-> r_c <= UNIT_Q30)
        else $error("curve value above one");
`endif

endmodule

/* verif/luma_perlin_gain_pixel_top_tb.sv */
// Self-checking testbench for the luma Perlin gain pixel block.
module luma_perlin_gain_pixel_top_tb
    import lpg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT = 75;
    localparam int LIMIT = 400000;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint EPS_LUM = ((64'sd1 << 28) + 50000) / 100000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [47:0] o_m_tdata;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = '0;
    logic [16:0] i_cfg_data = '0;

    luma_perlin_gain_pixel_top u_top (.*);

    always #5 i_clk = ~i_clk;

    // shadow registers
    logic [16:0] gain_r = GAIN_NEUTRAL;
    t_luma_mode  mode_r = LUMA_709;
    logic        clw_r = 0, clb_r = 0;

    logic [47:0] pixel_q[$];
    logic [47:0] expected_px[$];
    int  errors = 0, cycles = 0, n_out = 0;
    bit  steady = 0, took = 0;

    function automatic int msb_pos(longint unsigned x);
        int p = 0;
        while (p < 63 && (x >> (p + 1)) != 0) p++;
        return p;
    endfunction

    function automatic longint unsigned log2_frac(longint unsigned x, int p);
        longint unsigned m = x << (30 - p);
        longint unsigned f = 0;
        for (int i = 0; i < LOG_BITS; i++) begin
            m = (m * m) >> 30;
            f <<= 1;
            if (m >= (64'd1 << 31)) begin
                f |= 1;
                m >>= 1;
            end
        end
        return f;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned power_q30(longint unsigned bse, longint unsigned e);
        longint unsigned nl, nt, fp, ip, acc, root;
        int p;
        if (e == 0) return ONE_Q30;
        if (bse == 0) return 0;
        if (bse > ONE_Q30) bse = ONE_Q30;
        p = msb_pos(bse);
        nl = (longint'(30 - p) << LOG_BITS) - log2_frac(bse, p);
        nt = (e * nl) >> LOG_BITS;
        ip = nt >> LOG_BITS;
        fp = nt & ((64'd1 << LOG_BITS) - 1);
        if (ip >= 31) return 0;
        acc = ONE_Q30;
        root = ONE_Q30 >> 1;
        for (int k = 1; k <= LOG_BITS; k++) begin
            root = int_sqrt(root << 30);
            if ((fp >> (LOG_BITS - k)) & 1) acc = (acc * root) >> 30;
        end
        return acc >> ip;
    endfunction

    function automatic logic [15:0] scale_sample(longint x, longint unsigned c,
                                                 longint unsigned dm, bit dneg);
        bit neg = (x < 0) != dneg;
        longint unsigned xm = x < 0 ? -x : x;
        longint unsigned q = ((xm * c) >> 2) / dm;
        longint v;
        if (q > (64'd1 << 34)) q = 64'd1 << 34;
        v = neg ? -longint'(q) : longint'(q);
        if (clw_r && v > 4096) v = 4096;
        if (clb_r && v < 0) v = 0;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [47:0] adjust_pixel(logic [47:0] px);
        longint ch[3];
        longint lum, d, one, half;
        longint unsigned bse, c, dm, n, e;
        bit lower;
        logic [47:0] res;
        if (gain_r == GAIN_NEUTRAL) return px;
        for (int i = 0; i < 3; i++) ch[i] = longint'($signed(px[16*i +: 16]));
        case (mode_r)
            LUMA_709: lum = ch[0]*W709_R + ch[1]*W709_G + ch[2]*W709_B;
            LUMA_601: lum = ch[0]*W601_R + ch[1]*W601_G + ch[2]*W601_B;
            LUMA_AVG: lum = (ch[0] + ch[1] + ch[2]) * 65536 / 3;
            default: begin
                lum = ch[0];
                if (ch[1] > lum) lum = ch[1];
                if (ch[2] > lum) lum = ch[2];
                lum = lum * 65536;
            end
        endcase
        half = 64'sd1 << 27;
        one = 64'sd1 << 28;
        lower = lum < half;
        if (lower) bse = lum > 0 ? longint'(lum) * 8 : 0;
        else bse = lum < one ? longint'(one - lum) * 8 : 0;
        if (gain_r >= GAIN_FULL) begin
            c = lower ? 0 : ONE_Q30;
        end else begin
            n = 65536 - gain_r;
            e = (64'd16 << LOG_BITS) - ((longint'(msb_pos(n)) << LOG_BITS)
                + log2_frac(n, msb_pos(n)));
            c = power_q30(bse, e);
            c = lower ? (c >> 1) : ((2 * ONE_Q30 - c) >> 1);
        end
        d = lum + EPS_LUM;
        if (d == 0) d = 1;
        dm = d < 0 ? -d : d;
        for (int i = 0; i < 3; i++) res[16*i +: 16] = scale_sample(ch[i], c, dm, d < 0);
        return res;
    endfunction

    // input side: valid held until accepted
    always @(negedge i_clk) begin
        if (!i_s_tvalid || took) begin
            took = 0;
            if (pixel_q.size() > 0 && (steady || $urandom_range(0, 99) >= 25)) begin
                i_s_tdata <= pixel_q.pop_front();
                i_s_tvalid <= 1;
            end else begin
                i_s_tvalid <= 0;
            end
        end
        i_m_tready <= steady || $urandom_range(0, 99) >= 25;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            expected_px.push_back(adjust_pixel(i_s_tdata));
            took = 1;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_out++;
            if (expected_px.size() == 0) begin
                $error("unexpected word %h", o_m_tdata);
                errors++;
            end else begin
                logic [47:0] w;
                w = expected_px.pop_front();
                if (o_m_tdata[15:0] !== w[15:0]) begin
                    $error("red_out exp %h got %h", w[15:0], o_m_tdata[15:0]);
                    errors++;
                end
                if (o_m_tdata[31:16] !== w[31:16]) begin
                    $error("green_out exp %h got %h", w[31:16], o_m_tdata[31:16]);
                    errors++;
                end
                if (o_m_tdata[47:32] !== w[47:32]) begin
                    $error("blue_out exp %h got %h", w[47:32], o_m_tdata[47:32]);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [16:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [47:0] pack_px(int r, int g, int b);
        logic [15:0] rr = r[15:0], gg = g[15:0], bb = b[15:0];
        return {bb, gg, rr};
    endfunction

    function automatic int rand_sample();
        int k = $urandom_range(0, 9);
        if (k < 6) return $urandom_range(0, 4300);
        if (k < 7) return -int'($urandom_range(0, 600));
        return $urandom_range(0, 65535);
    endfunction

    task automatic drain();
        while (pixel_q.size() > 0 || i_s_tvalid || expected_px.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [16:0] g, t_luma_mode m, bit cw, bit cb, int n_rand);
        drain();
        write_reg(REG_GAIN, g);
        write_reg(REG_MODE, m);
        write_reg(REG_CLAMP_W, cw);
        write_reg(REG_CLAMP_B, cb);
        gain_r = g; mode_r = m; clw_r = cw; clb_r = cb;
        // extremes, zero, unity, half-luma, negatives
        pixel_q.push_back(pack_px(0, 0, 0));
        pixel_q.push_back(pack_px(32767, 32767, 32767));
        pixel_q.push_back(pack_px(-32768, -32768, -32768));
        pixel_q.push_back(pack_px(4096, 4096, 4096));
        pixel_q.push_back(pack_px(2048, 2048, 2048));
        pixel_q.push_back(pack_px(32767, -32768, 100));
        pixel_q.push_back(pack_px(-5, -3, -1));
        pixel_q.push_back(pack_px(1, 0, 0));
        // lum + eps exactly zero, reachable with CCIR weights
        if (m == LUMA_601) begin
            bit found = 0;
            for (int r = -200; r <= 200 && !found; r++)
                for (int gg = -200; gg <= 200 && !found; gg++) begin
                    longint rest = -EPS_LUM - r * 19595 - gg * 38470;
                    if (rest % 7471 == 0 && rest / 7471 >= -32768 && rest / 7471 <= 32767) begin
                        pixel_q.push_back(pack_px(r, gg, int'(rest / 7471)));
                        found = 1;
                    end
                end
        end
        for (int i = 0; i < n_rand; i++)
            pixel_q.push_back(pack_px(rand_sample(), rand_sample(), rand_sample()));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        run_phase(GAIN_NEUTRAL, LUMA_709, 0, 0, 40);
        run_phase(17'd0, LUMA_709, 0, 0, 60);
        run_phase(GAIN_FULL, LUMA_601, 1, 1, 60);
        run_phase(17'd16384, LUMA_AVG, 1, 0, 60);
        run_phase(17'd49152, LUMA_MAX, 0, 1, 60);
        steady = 1;
        run_phase(17'd1, LUMA_601, 0, 0, 80);
        steady = 0;
        run_phase(17'd65535, LUMA_709, 1, 1, 60);
        run_phase(17'd131071, LUMA_AVG, 0, 0, 40);
        for (int p = 0; p < 4; p++)
            run_phase($urandom_range(0, 65536), t_luma_mode'($urandom_range(0, 3)),
                      $urandom_range(0, 1), $urandom_range(0, 1), 55);
        drain();
        $display("%0d pixels checked across gain extremes, all luma modes and clamp mixes",
                 n_out);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
